/* rtl/core/mh_pkg.sv */
// shared types, constants and angle table of the magnetometer heading block
package mh_pkg;

	// number of cordic iterations, one pipeline stage each (8 to 24)
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;

	localparam int AXIS_W  = 16;
	localparam int OFF_W   = 13;
	localparam int DECL_W  = 16;
	localparam int HEAD_W  = 16;
	localparam int FRAC_SH = 24;
	// holds an axis scaled by 2^24 plus cordic growth with headroom
	localparam int VEC_W   = 44;
	localparam int ANG_W   = 32;

	localparam logic [AXIS_W-1:0] OVF_CODE  = 16'hF000;
	localparam logic [ANG_W-1:0]  HALF_TURN = 32'h8000_0000;
	localparam int                HUND_TURN = 36000;

	localparam logic signed [DECL_W-1:0] DECL_RESET = 16'sd235;

	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_OFFSET_X    = 2'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y    = 2'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET_Z    = 2'd2;
	localparam logic [IDX_W-1:0] REG_DECLINATION = 2'd3;

	// atan(2^-i) as a fraction of a full turn, 2^32 per turn
	localparam logic [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41721,     32'd20860,
		32'd10430,     32'd5215,      32'd2607,      32'd1303,
		32'd651,       32'd325,       32'd162,       32'd81
	};

	typedef struct packed {
		logic signed [VEC_W-1:0] re;
		logic signed [VEC_W-1:0] im;
		logic [ANG_W-1:0]        ang;
		logic                    ovf;
		logic                    zero;
	} vec_t;

endpackage

/* rtl/core/mh_front.sv */
// offset correction, overflow check and half-turn pre-rotation
module mh_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [mh_pkg::AXIS_W-1:0]    x_raw,
	input  logic signed [mh_pkg::AXIS_W-1:0]    z_raw,
	input  logic signed [mh_pkg::AXIS_W-1:0]    y_raw,
	input  logic signed [mh_pkg::OFF_W-1:0]     off_x,
	input  logic signed [mh_pkg::OFF_W-1:0]     off_y,
	input  logic signed [mh_pkg::OFF_W-1:0]     off_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output mh_pkg::vec_t                        out_vec
);

	logic                             v_s1, v_s2;
	logic                             rdy_s1, rdy_s2;
	logic signed [mh_pkg::AXIS_W-1:0] cx, cy, cz;
	logic signed [mh_pkg::AXIS_W-1:0] x_s1, z_s1;
	logic                             ovf_s1;
	logic signed [mh_pkg::VEC_W-1:0]  re_sc, im_sc;
	mh_pkg::vec_t                     pre;
	mh_pkg::vec_t                     vec_s2;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// subtraction wraps to the axis width
	assign cx = x_raw - mh_pkg::AXIS_W'(off_x);
	assign cy = y_raw - mh_pkg::AXIS_W'(off_y);
	assign cz = z_raw - mh_pkg::AXIS_W'(off_z);

	assign re_sc = mh_pkg::VEC_W'(z_s1) <<< mh_pkg::FRAC_SH;
	assign im_sc = mh_pkg::VEC_W'(x_s1) <<< mh_pkg::FRAC_SH;

	always_comb begin
		pre.ovf  = ovf_s1;
		pre.zero = (x_s1 == '0) && (z_s1 == '0);
		if (z_s1 < 0) begin
			pre.re  = -re_sc;
			pre.im  = -im_sc;
			pre.ang = mh_pkg::HALF_TURN;
		end else begin
			pre.re  = re_sc;
			pre.im  = im_sc;
			pre.ang = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			x_s1   <= cx;
			z_s1   <= cz;
			ovf_s1 <= (cx == mh_pkg::OVF_CODE) || (cy == mh_pkg::OVF_CODE) ||
			          (cz == mh_pkg::OVF_CODE);
		end
		if (rdy_s2 && v_s1) vec_s2 <= pre;
	end

	assign out_valid = v_s2;
	assign out_vec   = vec_s2;

endmodule

/* rtl/core/mh_cordic.sv */
// vectoring cordic, one registered stage per iteration
module mh_cordic (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  mh_pkg::vec_t in_vec,
	output logic         out_valid,
	input  logic         out_ready,
	output mh_pkg::vec_t out_vec
);

	localparam int N = mh_pkg::CORDIC_STEPS;

	mh_pkg::vec_t   vec_s [N];
	logic [N-1:0]   v_s;
	logic [N:0]     rdy;

	assign rdy[N]   = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < N; k++) begin : g_step
		mh_pkg::vec_t            cur;
		mh_pkg::vec_t            nxt;
		logic                    cur_v;
		logic signed [mh_pkg::VEC_W-1:0] re_sh, im_sh;

		if (k == 0) begin : g_first
			assign cur   = in_vec;
			assign cur_v = in_valid;
		end else begin : g_rest
			assign cur   = vec_s[k-1];
			assign cur_v = v_s[k-1];
		end

		assign rdy[k] = !v_s[k] || rdy[k+1];
		assign re_sh  = cur.re >>> k;
		assign im_sh  = cur.im >>> k;

		// turn toward the real axis
		always_comb begin
			nxt = cur;
			if (!cur.im[mh_pkg::VEC_W-1]) begin
				nxt.re  = cur.re + im_sh;
				nxt.im  = cur.im - re_sh;
				nxt.ang = cur.ang + mh_pkg::ATAN_TAB[k];
			end else begin
				nxt.re  = cur.re - im_sh;
				nxt.im  = cur.im + re_sh;
				nxt.ang = cur.ang - mh_pkg::ATAN_TAB[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && cur_v) vec_s[k] <= nxt;
		end
	end

	assign out_valid = v_s[N-1];
	assign out_vec   = vec_s[N-1];

endmodule

/* rtl/core/mh_back.sv */
// angle to hundredths of a degree, declination and wrap into one turn
module mh_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mh_pkg::vec_t                      in_vec,
	input  logic signed [mh_pkg::DECL_W-1:0]  decl,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mh_pkg::HEAD_W-1:0]         heading,
	output logic                              overflow
);

	localparam int PROD_W = mh_pkg::ANG_W + mh_pkg::HEAD_W;
	localparam int SUM_W  = mh_pkg::HEAD_W + 2;

	logic                        v_s1, v_s2;
	logic                        rdy_s1, rdy_s2;
	logic [mh_pkg::ANG_W-1:0]    ang_adj;
	logic [PROD_W-1:0]           prod;
	logic [mh_pkg::HEAD_W-1:0]   h_s1;
	logic                        ovf_s1;
	logic signed [SUM_W-1:0]     sum;
	logic signed [SUM_W-1:0]     wrapped;
	logic [mh_pkg::HEAD_W-1:0]   head_s2;
	logic                        ovf_s2;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// zero vector gives angle 0 before the half turn
	assign ang_adj = (in_vec.zero ? '0 : in_vec.ang) + mh_pkg::HALF_TURN;
	assign prod    = PROD_W'(ang_adj) * PROD_W'(mh_pkg::HUND_TURN);

	assign sum = signed'({2'b00, h_s1}) + SUM_W'(decl);

	always_comb begin
		if (sum < 0) begin
			wrapped = sum + SUM_W'(mh_pkg::HUND_TURN);
		end else if (sum >= SUM_W'(mh_pkg::HUND_TURN)) begin
			wrapped = sum - SUM_W'(mh_pkg::HUND_TURN);
		end else begin
			wrapped = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			h_s1   <= prod[PROD_W-1:mh_pkg::ANG_W];
			ovf_s1 <= in_vec.ovf;
		end
		if (rdy_s2 && v_s1) begin
			head_s2 <= ovf_s1 ? '0 : wrapped[mh_pkg::HEAD_W-1:0];
			ovf_s2  <= ovf_s1;
		end
	end

	assign out_valid = v_s2;
	assign heading   = head_s2;
	assign overflow  = ovf_s2;

endmodule

/* rtl/core/magnetometer_heading.sv */
// top level of the magnetometer compass heading block
//
// takes one three-axis magnetometer sample per transfer and returns one compass
// heading per sample, in hundredths of a degree (0 to 35999). each axis has a
// hard-iron offset subtracted, wrapping to 16 bits; if any corrected axis hits
// the sensor overflow code -4096 the result has heading 0 and the overflow flag
// set. otherwise heading = atan2(x, z) + 180 degrees + declination, wrapped into
// one turn and truncated. atan2 runs as a vectoring cordic with one register
// stage per iteration, so the block takes a new sample every clock cycle while
// the output side keeps taking results; each sample passes in order through the
// front-end registers, the cordic stages and the back-end registers. every
// stage has its own valid bit and the stall chain fills bubbles, so input keeps
// flowing while a finished result waits at the output register. registers are
// written through cfg_we/cfg_index/cfg_wdata: 0 offset_x, 1 offset_y, 2 offset_z
// (13-bit signed each) and 3 declination (16-bit signed hundredths, reset 2.35
// degrees); write them only while no sample is in flight.
module magnetometer_heading (
	input  logic                       clk,
	input  logic                       arst_n,
	// input sample stream
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [47:0]                s_axis_tdata,   // x_raw, z_raw, y_raw
	// heading stream
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [15:0]                m_axis_tdata,   // heading
	output logic [0:0]                 m_axis_tuser,   // overflow
	// register writes
	input  logic                       cfg_we,
	input  logic [mh_pkg::IDX_W-1:0]   cfg_index,
	input  logic [15:0]                cfg_wdata
);

	// configuration registers
	logic signed [mh_pkg::OFF_W-1:0]  off_x_q, off_y_q, off_z_q;
	logic signed [mh_pkg::DECL_W-1:0] decl_q;

	// links between the front end, the cordic pipe and the back end
	logic         fr_valid, fr_ready;
	mh_pkg::vec_t fr_vec;
	logic         co_valid, co_ready;
	mh_pkg::vec_t co_vec;
	logic         ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			decl_q  <= mh_pkg::DECL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mh_pkg::REG_OFFSET_X:    off_x_q <= cfg_wdata[mh_pkg::OFF_W-1:0];
				mh_pkg::REG_OFFSET_Y:    off_y_q <= cfg_wdata[mh_pkg::OFF_W-1:0];
				mh_pkg::REG_OFFSET_Z:    off_z_q <= cfg_wdata[mh_pkg::OFF_W-1:0];
				mh_pkg::REG_DECLINATION: decl_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// offset correction, overflow detect, pre-rotation into the right half plane
	mh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.x_raw     (s_axis_tdata[15:0]),
		.z_raw     (s_axis_tdata[31:16]),
		.y_raw     (s_axis_tdata[47:32]),
		.off_x     (off_x_q),
		.off_y     (off_y_q),
		.off_z     (off_z_q),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_vec   (fr_vec)
	);

	// one iteration per stage, angle accumulated as a 32-bit binary angle
	mh_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_vec    (fr_vec),
		.out_valid (co_valid),
		.out_ready (co_ready),
		.out_vec   (co_vec)
	);

	// scale to hundredths, add declination, wrap, output register
	mh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (co_valid),
		.in_ready  (co_ready),
		.in_vec    (co_vec),
		.decl      (decl_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.heading   (m_axis_tdata),
		.overflow  (ovf)
	);

	assign m_axis_tuser = ovf;

`ifndef SYNTH
	// an overflowed sample never carries a heading
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("overflow result with nonzero heading");

	// heading stays inside one turn
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata < 16'(mh_pkg::HUND_TURN))
		else $error("heading outside one turn");

	// the input side only backs up when the output holds an untaken result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled while output free");

	// a declination write lands in its register
	a_decl_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == mh_pkg::REG_DECLINATION |=> decl_q == $past(cfg_wdata))
		else $error("declination write lost");
`endif

endmodule

/* verif/mh_heading_checker.sv */
// checker for the magnetometer heading block: watches both streams and the register port
module mh_heading_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	input  logic [47:0]              s_axis_tdata,   // x_raw, z_raw, y_raw
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic [15:0]              m_axis_tdata,   // heading
	input  logic [0:0]               m_axis_tuser,   // overflow
	input  logic                     cfg_we,
	input  logic [mh_pkg::IDX_W-1:0] cfg_index,
	input  logic [15:0]              cfg_wdata,
	output int                       errors,
	output int                       pending
);

	localparam logic [15:0] OVERFLOW_WORD = 16'hF000;   // -4096
	localparam logic [31:0] HALF_ROT      = 32'h8000_0000;
	localparam int          HUNDREDTHS    = 36000;
	localparam int          ARC_LEN       = 24;

	// atan(2^-i), 2^32 per full turn
	localparam logic [31:0] ARC_TAB [ARC_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41721,     32'd20860,
		32'd10430,     32'd5215,      32'd2607,      32'd1303,
		32'd651,       32'd325,       32'd162,       32'd81
	};

	typedef struct {
		logic [15:0] heading;
		logic        overflow;
	} heading_t;

	logic signed [12:0] off_x, off_y, off_z;
	logic signed [15:0] decl;
	heading_t           heading_q [$];

	initial errors = 0;

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
		errors++;
	endtask

	function automatic logic [15:0] remove_offset(logic [15:0] raw, logic signed [12:0] off);
		int diff;
		diff = int'($signed(raw)) - int'(off);
		return diff[15:0];
	endfunction

	// vectoring rotation, arithmetic shifts floor like the hardware
	function automatic logic [31:0] vector_angle(logic signed [15:0] num,
		logic signed [15:0] den);
		longint re, im, nre, nim;
		logic [31:0] ang;
		ang = '0;
		if (num == 0 && den == 0)
			return '0;
		re = longint'(den) <<< 24;
		im = longint'(num) <<< 24;
		if (re < 0) begin
			re  = -re;
			im  = -im;
			ang = HALF_ROT;
		end
		for (int i = 0; i < mh_pkg::CORDIC_STEPS && i < ARC_LEN; i++) begin
			if (im >= 0) begin
				nre = re + (im >>> i);
				nim = im - (re >>> i);
				ang = ang + ARC_TAB[i];
			end else begin
				nre = re - (im >>> i);
				nim = im + (re >>> i);
				ang = ang - ARC_TAB[i];
			end
			re = nre;
			im = nim;
		end
		return ang;
	endfunction

	function automatic heading_t predict_heading(logic [47:0] word);
		heading_t    res;
		logic [15:0] x, z, y;
		logic [31:0] b;
		longint      prod;
		int          h, r;
		x = remove_offset(word[15:0],  off_x);
		z = remove_offset(word[31:16], off_z);
		y = remove_offset(word[47:32], off_y);
		if (x == OVERFLOW_WORD || y == OVERFLOW_WORD || z == OVERFLOW_WORD) begin
			res.heading  = '0;
			res.overflow = 1'b1;
			return res;
		end
		b    = vector_angle(x, z) + HALF_ROT;
		prod = longint'(b) * HUNDREDTHS;
		h    = int'(prod >> 32);
		r    = (h + int'(decl)) % HUNDREDTHS;
		if (r < 0)
			r += HUNDREDTHS;
		res.heading  = r[15:0];
		res.overflow = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heading_t want;
		if (!arst_n) begin
			off_x = '0;
			off_y = '0;
			off_z = '0;
			decl  = 16'sd235;
			heading_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mh_pkg::REG_OFFSET_X:    off_x = $signed(cfg_wdata[12:0]);
					mh_pkg::REG_OFFSET_Y:    off_y = $signed(cfg_wdata[12:0]);
					mh_pkg::REG_OFFSET_Z:    off_z = $signed(cfg_wdata[12:0]);
					mh_pkg::REG_DECLINATION: decl  = $signed(cfg_wdata);
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				heading_q.push_back(predict_heading(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (heading_q.size() == 0) begin
					report_mismatch("heading with none pending", -1, int'(m_axis_tdata));
				end else begin
					want = heading_q.pop_front();
					if (m_axis_tdata !== want.heading)
						report_mismatch("heading", int'(want.heading), int'(m_axis_tdata));
					if (m_axis_tuser[0] !== want.overflow)
						report_mismatch("overflow", int'(want.overflow),
							int'(m_axis_tuser[0]));
				end
			end
		end
		pending = heading_q.size();
	end

endmodule

/* verif/tb.sv */
// top of the magnetometer heading testbench: clock, reset, stimulus and verdict
module tb;

	localparam int GAP_MAX        = 16;
	localparam int SETTLE_CYCLES  = 30;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_COUNT    = 8;
	localparam int PHASE_ITEMS    = 50;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [47:0]              s_axis_tdata  = '0;   // x_raw, z_raw, y_raw
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [15:0]              m_axis_tdata;         // heading
	logic [0:0]               m_axis_tuser;         // overflow
	logic                     cfg_we        = 1'b0;
	logic [mh_pkg::IDX_W-1:0] cfg_index     = mh_pkg::REG_OFFSET_X;
	logic [15:0]              cfg_wdata     = '0;

	int                 errors;
	int                 pending;
	int                 idle_cycles   = 0;

	// idling modes of both sides, and the request for one long output stall
	bit                 send_burst    = 1'b0;
	bit                 take_burst    = 1'b0;
	bit                 hold_req      = 1'b0;

	// stimulus-side copy of the offsets, used to aim samples at special cases
	logic signed [12:0] cur_off_x     = '0;
	logic signed [12:0] cur_off_y     = '0;
	logic signed [12:0] cur_off_z     = '0;

	magnetometer_heading i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	mh_heading_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// watchdog: any cycle with no transfer on either stream counts toward the limit
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// offer one sample; entered and left at a falling edge, valid stays up on exit
	task automatic send_sample(input logic [15:0] x, input logic [15:0] z,
		input logic [15:0] y);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {y, z, x};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// stop offering and wait until every heading has come back, then a little more
	task automatic wait_drained(input int extra);
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// all four registers, one per cycle; offset words carry random upper bits
	task automatic configure(input logic signed [12:0] ox, input logic signed [12:0] oy,
		input logic signed [12:0] oz, input logic signed [15:0] decl);
		cfg_we    <= 1'b1;
		cfg_index <= mh_pkg::REG_OFFSET_X;
		cfg_wdata <= {3'($urandom), ox};
		@(negedge clk);
		cfg_index <= mh_pkg::REG_OFFSET_Y;
		cfg_wdata <= {3'($urandom), oy};
		@(negedge clk);
		cfg_index <= mh_pkg::REG_OFFSET_Z;
		cfg_wdata <= {3'($urandom), oz};
		@(negedge clk);
		cfg_index <= mh_pkg::REG_DECLINATION;
		cfg_wdata <= decl;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_off_x = ox;
		cur_off_y = oy;
		cur_off_z = oz;
	endtask

	// raw word that corrects to the given value under an offset
	function automatic logic [15:0] aim(input logic signed [12:0] off, input int target);
		return 16'(int'(off) + target);
	endfunction

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0001;
			4: return 16'h0000;
			default: return 16'hF000;
		endcase
	endfunction

	// random sample mix: uniform words, near-zero vectors, overflow on one axis,
	// exact zero vector, axis-aligned vectors and extreme words
	task automatic send_random();
		logic [15:0] x, z, y;
		x = 16'($urandom);
		z = 16'($urandom);
		y = 16'($urandom);
		case ($urandom_range(0, 9))
			4, 5: begin
				x = aim(cur_off_x, $urandom_range(0, 400) - 200);
				z = aim(cur_off_z, $urandom_range(0, 400) - 200);
			end
			6: begin
				case ($urandom_range(0, 2))
					0: x = aim(cur_off_x, -4096);
					1: z = aim(cur_off_z, -4096);
					default: y = aim(cur_off_y, -4096);
				endcase
			end
			7: begin
				x = aim(cur_off_x, 0);
				z = aim(cur_off_z, 0);
			end
			8: begin
				if ($urandom_range(0, 1))
					x = aim(cur_off_x, 0);
				else
					z = aim(cur_off_z, 0);
			end
			9: begin
				x = pick_extreme();
				z = pick_extreme();
				y = pick_extreme();
			end
			default: ;
		endcase
		send_sample(x, z, y);
	endtask

	// output side: own idling, with one long stall when asked for
	initial begin : take_results
		int gap;
		int taken;
		taken = 0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (taken % 40 == 0)
				take_burst = ($urandom_range(0, 2) == 0);
			if (hold_req) begin
				gap      = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				gap = take_burst ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic signed [15:0] decl;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part under reset settings (no offsets, declination 2.35 degrees)
		send_sample(16'h0000, 16'h0000, 16'h0000);   // zero vector
		send_sample(16'h0000, 16'd1000, 16'h0000);   // x zero, z positive: heading 180 degrees plus declination
		send_sample(16'd1000, 16'h0000, 16'h0000);
		send_sample(16'h0000, -16'sd1000, 16'h0000); // z negative, x zero
		send_sample(-16'sd1000, 16'h0000, 16'h0000);
		send_sample(16'd1000, -16'sd1000, 16'h0000);
		send_sample(-16'sd1000, -16'sd1000, 16'h0000);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_sample(16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h7FFF, 16'h8000, 16'h0000);
		send_sample(16'h8000, 16'h7FFF, 16'h0000);
		send_sample(16'h0000, 16'h8000, 16'h0000);
		send_sample(16'h8000, 16'h0000, 16'h0000);
		send_sample(16'h0001, 16'hFFFF, 16'h0000);
		// overflow code on each axis, then on all three
		send_sample(16'hF000, 16'd500, 16'd500);
		send_sample(16'd500, 16'hF000, 16'd500);
		send_sample(16'd500, 16'd500, 16'hF000);
		send_sample(16'hF000, 16'hF000, 16'hF000);
		// neighbors of the overflow code are ordinary samples
		send_sample(16'hF001, 16'hEFFF, 16'hF001);
		send_sample(16'd300, 16'd400, 16'hEFFF);
		send_sample(16'hFFFF, 16'h0001, 16'h7FFF);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			wait_drained(SETTLE_CYCLES);
			case (phase)
				0: configure(-13'sd4096, -13'sd4096, -13'sd4096, -16'sd18000);
				1: configure(13'sd4095, 13'sd4095, 13'sd4095, 16'sd18000);
				2: configure(13'sd0, 13'sd0, 13'sd0, 16'sh7FFF);
				3: configure(13'($urandom), 13'($urandom), 13'($urandom), 16'sh8000);
				default: begin
					decl = 16'($urandom_range(0, 36000) - 18000);
					configure(13'($urandom), 13'($urandom), 13'($urandom), decl);
				end
			endcase
			send_burst = ($urandom_range(0, 2) == 0);
			// fill the pipeline against a long output stall
			if (phase == 2) begin
				send_burst = 1'b1;
				hold_req   = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// the sender once waits for every heading mid-phase
				if (phase == 5 && n == PHASE_ITEMS / 2)
					wait_drained(0);
				send_random();
			end
		end

		wait_drained(SETTLE_CYCLES);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/mh_pkg.sv
rtl/core/mh_front.sv
rtl/core/mh_cordic.sv
rtl/core/mh_back.sv
rtl/core/magnetometer_heading.sv
verif/mh_heading_checker.sv
verif/tb.sv
